@@ rtl/rmg_pkg.sv @@
// Package for the random mute gate: shared constants, register indexes and the
// structs passed between the configuration, control and scaling modules.
// No dependencies.
`default_nettype none

package rmg_pkg;

  // Amplitude and probability are U1.16, so unity is 2^16.
  localparam int unsigned GainW = 17;
  localparam logic [GainW-1:0] GAIN_ONE = 17'h10000;

  // Configuration port geometry.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 17;

  // Register indexes.
  localparam logic [CfgAddrW-1:0] REG_PROB_KNOB  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_FADE_EN    = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_FADE_STEP  = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_TRIG_HIGH  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_TRIG_LOW   = 3'd4;

  // Register reset values.
  localparam logic [16:0]        RST_PROB_KNOB = 17'd32768;
  localparam logic               RST_FADE_EN   = 1'b0;
  localparam logic [16:0]        RST_FADE_STEP = 17'd328;
  localparam logic signed [15:0] RST_TRIG_HIGH = 16'sd2048;
  localparam logic signed [15:0] RST_TRIG_LOW  = 16'sd0;

  // Stream payload widths.
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;

  // Current register contents.
  typedef struct packed {
    logic [16:0]        prob_knob;
    logic               fade_en;
    logic [16:0]        fade_step;
    logic signed [15:0] trig_high;
    logic signed [15:0] trig_low;
  } cfg_t;

  // One unpacked input transaction.
  typedef struct packed {
    logic               frame_start;
    logic signed [15:0] trigger_level;
    logic signed [15:0] cv_level;
    logic               cv_present;
    logic [15:0]        random_draw;
    logic signed [15:0] sample_in;
  } item_t;

  // Item handed from the control pipeline to the scaling stage.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] sample;
    logic [GainW-1:0]   gain;
  } scale_req_t;

endpackage

`default_nettype wire

@@ rtl/rmg_cfg.sv @@
// Configuration register file of the random mute gate.
// Depends on rmg_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module rmg_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rmg_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [rmg_pkg::CfgDataW-1:0]  cfg_wdata,
  output rmg_pkg::cfg_t                      cfg
);

  rmg_pkg::cfg_t cfg_r;
  rmg_pkg::cfg_t cfg_nxt;

  // Decode a write into the addressed register; other indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        rmg_pkg::REG_PROB_KNOB: cfg_nxt.prob_knob = cfg_wdata;
        rmg_pkg::REG_FADE_EN:   cfg_nxt.fade_en   = cfg_wdata[0];
        rmg_pkg::REG_FADE_STEP: cfg_nxt.fade_step = cfg_wdata;
        rmg_pkg::REG_TRIG_HIGH: cfg_nxt.trig_high = $signed(cfg_wdata[15:0]);
        rmg_pkg::REG_TRIG_LOW:  cfg_nxt.trig_low  = $signed(cfg_wdata[15:0]);
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prob_knob <= rmg_pkg::RST_PROB_KNOB;
      cfg_r.fade_en   <= rmg_pkg::RST_FADE_EN;
      cfg_r.fade_step <= rmg_pkg::RST_FADE_STEP;
      cfg_r.trig_high <= rmg_pkg::RST_TRIG_HIGH;
      cfg_r.trig_low  <= rmg_pkg::RST_TRIG_LOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/rmg_ctrl.sv @@
// Control pipeline of the random mute gate: input register, probability stage,
// and the state stage (Schmitt trigger, mute decision, amplitude update).
// Depends on rmg_pkg for cfg_t, item_t and scale_req_t.
`default_nettype none

module rmg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rmg_pkg::cfg_t        cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rmg_pkg::item_t       in_item,
  input  wire logic                 s3_ready,
  output rmg_pkg::scale_req_t       s3
);

  // Reciprocal of 5 scaled by 2^22, with the factor 16 of the CV scaling folded
  // in: floor(mag * 16 / 5) = (mag * DIV5_RECIP) >> 18, exact for 16-bit mag.
  localparam logic [19:0] DIV5_RECIP = 20'd838861;

  // CV term in U1.16: cv * 16 / 5, truncated toward zero.
  function automatic logic signed [18:0] cv_term(input logic signed [15:0] cv);
    logic [15:0] mag;
    logic [35:0] prod;
    logic [17:0] q;
    mag  = cv[15] ? (~cv + 16'd1) : cv;
    prod = {20'd0, mag} * {16'd0, DIV5_RECIP};
    q    = prod[35:18];
    return cv[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Saturate a signed sum to the 0..1.0 range of U1.16.
  function automatic logic [16:0] clamp_one(input logic signed [18:0] v);
    if (v < 0) begin
      return 17'd0;
    end else if (v > $signed({2'b00, rmg_pkg::GAIN_ONE})) begin
      return rmg_pkg::GAIN_ONE;
    end else begin
      return v[16:0];
    end
  endfunction

  // Stage 1: input register.
  logic           v1_r;
  rmg_pkg::item_t item1_r;

  // Stage 2: probability and trigger compares.
  logic               v2_r;
  logic               frame2_r;
  logic               ge_hi2_r;
  logic               le_lo2_r;
  logic [15:0]        draw2_r;
  logic [16:0]        prob2_r;
  logic signed [15:0] sample2_r;

  // Stage 3: sample waiting for the multiplier.
  logic               v3_r;
  logic signed [15:0] sample3_r;

  // Control state.
  logic        trig_hi_r;
  logic        muted_r;
  logic [16:0] gain_r;
  logic        trig_hi_nxt;
  logic        muted_nxt;
  logic [16:0] gain_nxt;

  // Stage handshakes: a stage may load when it is empty or drains this cycle.
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic adv2;

  assign rdy3     = !v3_r || s3_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign adv2     = v2_r && rdy3;
  assign in_ready = rdy1;

  // Probability: knob plus optional CV term, clamped.
  logic signed [18:0] prob_sum;
  logic [16:0]        prob_nxt;
  logic               ge_hi;
  logic               le_lo;

  always_comb begin
    prob_sum = $signed({2'b00, cfg.prob_knob})
             + (item1_r.cv_present ? cv_term(item1_r.cv_level) : 19'sd0);
    prob_nxt = clamp_one(prob_sum);
    ge_hi    = $signed(item1_r.trigger_level) >= $signed(cfg.trig_high);
    le_lo    = $signed(item1_r.trigger_level) <= $signed(cfg.trig_low);
  end

  // State update: Schmitt trigger, mute draw on a rising edge, amplitude.
  logic               rising;
  logic signed [18:0] fade_sum;

  always_comb begin
    rising      = !trig_hi_r && ge_hi2_r;
    trig_hi_nxt = trig_hi_r ? !le_lo2_r : ge_hi2_r;
    muted_nxt   = rising ? ({1'b0, draw2_r} < prob2_r) : muted_r;
    fade_sum    = muted_nxt ? $signed({2'b00, gain_r}) - $signed({2'b00, cfg.fade_step})
                            : $signed({2'b00, gain_r}) + $signed({2'b00, cfg.fade_step});
    if (cfg.fade_en) begin
      gain_nxt = clamp_one(fade_sum);
    end else begin
      gain_nxt = muted_nxt ? 17'd0 : rmg_pkg::GAIN_ONE;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      item1_r <= in_item;
    end
    if (rdy2 && v1_r) begin
      frame2_r  <= item1_r.frame_start;
      ge_hi2_r  <= ge_hi;
      le_lo2_r  <= le_lo;
      draw2_r   <= item1_r.random_draw;
      prob2_r   <= prob_nxt;
      sample2_r <= item1_r.sample_in;
    end
    if (adv2) begin
      sample3_r <= sample2_r;
    end
  end

  // Control state moves only when a frame-start transaction leaves stage 2.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_hi_r <= 1'b0;
      muted_r   <= 1'b0;
      gain_r    <= 17'd0;
    end else if (adv2 && frame2_r) begin
      trig_hi_r <= trig_hi_nxt;
      muted_r   <= muted_nxt;
      gain_r    <= gain_nxt;
    end
  end

  // gain_r changes only when stage 3 loads, so it belongs to the stage 3 sample.
  assign s3.valid  = v3_r;
  assign s3.sample = sample3_r;
  assign s3.gain   = gain_r;

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= rmg_pkg::GAIN_ONE)
    else $error("amplitude above unity");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv2 |=> $stable(gain_r) && $stable(muted_r) && $stable(trig_hi_r))
    else $error("control state changed without a transaction leaving stage 2");

  a_hard_switch: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && frame2_r && !cfg.fade_en |=>
      gain_r == (muted_r ? 17'd0 : rmg_pkg::GAIN_ONE))
    else $error("amplitude not switched to its target with fade off");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !s3_ready |=> v3_r && $stable(sample3_r))
    else $error("stage 3 item lost while the scaler stalls");

endmodule

`default_nettype wire

@@ rtl/rmg_scale.sv @@
// Output stage of the random mute gate: multiplies the sample by the amplitude,
// truncates toward zero and holds the result in the output register.
// Depends on rmg_pkg for scale_req_t.
`default_nettype none

module rmg_scale (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmg_pkg::scale_req_t           s3,
  output logic                               s3_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rmg_pkg::OutDataW-1:0]       out_data
);

  logic                         out_v_r;
  logic [rmg_pkg::OutDataW-1:0] out_data_r;

  // Signed product, then a bias on negative values so the shift rounds to zero.
  logic signed [33:0] prod;
  logic signed [33:0] adj;

  always_comb begin
    prod = s3.sample * $signed({1'b0, s3.gain});
    adj  = prod + (prod[33] ? 34'sd65535 : 34'sd0);
  end

  assign s3_ready = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s3_ready) begin
      out_v_r <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3.valid) begin
      out_data_r <= adj[31:16];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/random_mute_gate_with_fade.sv @@
// Random mute gate with fade: top level.
// Depends on rmg_pkg, rmg_cfg, rmg_ctrl and rmg_scale.
//
// Use: each input transaction is one channel sample. in_tuser marks the first
// channel of a frame; only that transaction runs the control path (Schmitt
// trigger on the trigger voltage, random mute decision on a rising edge, and
// the amplitude step). Every sample, the first one included, leaves scaled by
// the amplitude after that update, one output transaction per input.
// Registers must be written through cfg_wr_en/cfg_addr/cfg_wdata only while
// no transaction is in flight (not enforced by the block); indexes above the
// register list are ignored. A transaction passes the input register,
// probability stage, state stage and multiplier into the output register
// before out_tvalid. With out_tready high, throughput is one transaction per
// cycle: the amplitude recurrence closes within the single state stage.
// Reset (rst_n low, synchronous) empties the pipeline, restores the register
// defaults, and clears trigger, mute and amplitude, so output is silent until
// the first frame start. When out_tready is low, the output register holds its
// transaction and the stages behind it keep filling; in_tready drops only once
// every stage is occupied.
`default_nettype none

module random_mute_gate_with_fade (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // trigger_level[15:0], cv_level[31:16], cv_present[32], random_draw[48:33],
  // sample_in[64:49], zero pad[71:65]
  input  wire logic [rmg_pkg::InDataW-1:0]   in_tdata,
  // frame_start[0]
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // sample_out[15:0]
  output logic [rmg_pkg::OutDataW-1:0]       out_tdata,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rmg_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [rmg_pkg::CfgDataW-1:0]  cfg_wdata
);

  rmg_pkg::cfg_t       cfg;
  rmg_pkg::item_t      in_item;
  rmg_pkg::scale_req_t s3;
  logic                s3_ready;

  // Unpack the input transaction.
  always_comb begin
    in_item.frame_start   = in_tuser;
    in_item.trigger_level = $signed(in_tdata[15:0]);
    in_item.cv_level      = $signed(in_tdata[31:16]);
    in_item.cv_present    = in_tdata[32];
    in_item.random_draw   = in_tdata[48:33];
    in_item.sample_in     = $signed(in_tdata[64:49]);
  end

  rmg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s3_ready (s3_ready),
    .s3       (s3)
  );

  rmg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3        (s3),
    .s3_ready  (s3_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire
